### design/p2sca_pkg.sv
`default_nettype none
package p2sca_pkg;
    localparam int NUM_POOLS      = 8;
    localparam int MAX_POOL_BYTES = 65536;
    localparam int HEADER_BYTES   = 16;
    localparam int ADDR_W         = 19;
    localparam int FILL_W         = 17;
    localparam int CLASS_W        = 5;
    localparam int CLASS_COUNT    = 32;
    localparam int LIST_DEPTH     = 17;
    localparam int LIST_AW        = 5;
    localparam int SLOT_W         = 14;
    localparam int SLOT_LSB       = 5;
    localparam int POOL_W         = 3;
    localparam int POOL_CNT_W     = 4;
    localparam int POOL_SHIFT     = 16;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_IGNORED   = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE = 2'd2;
    localparam logic [1:0] ST_NO_POOLS  = 2'd3;

    localparam logic       OP_ALLOC = 1'b0;
    localparam logic       OP_FREE  = 1'b1;

    localparam logic CFG_POOL_SIZE     = 1'b0;
    localparam logic CFG_POOLS_ALLOWED = 1'b1;

    typedef struct packed {
        logic              op;
        logic [31:0]       req_bytes;
        logic [ADDR_W-1:0] block_addr;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr_out;
        logic [1:0]        status;
        logic              reused;
    } rsp_t;

    typedef struct packed {
        logic        index;
        logic [31:0] data;
    } cfg_t;
endpackage
`default_nettype wire

### design/p2sca_if.sv
`default_nettype none
interface p2sca_req_if;
    logic               valid;
    logic               ready;
    p2sca_pkg::req_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface p2sca_rsp_if;
    logic               valid;
    logic               ready;
    p2sca_pkg::rsp_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface p2sca_cfg_if;
    logic               valid;
    logic               ready;
    p2sca_pkg::cfg_t    payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

### design/p2sca_ram.sv
`default_nettype none
module p2sca_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### design/pow2_size_class_allocator.sv
`default_nettype none
// Power-of-two size-class allocator.
// Channels: req (sink) carries op/req_bytes/block_addr; rsp (source) returns
// addr_out/status/reused, exactly one item per request; cfg (sink) writes
// register 0 pool_size and register 1 pools_allowed, always ready.
// Alloc rounds req_bytes+16 up to 2^c. A nonempty free list for c is popped;
// otherwise the first open pool with room is bump-carved, opening a new pool
// if needed. Free reads the slot's class; if 2^class fits, it heads that list.
// Timing: an item is taken in IDLE; the first READ phase reads the list head
// and the slot class; the second reads the popped head's next link (alloc) or
// the head of the stored class (free); EXEC uses the read data, writes back
// and loads the result register, holding while the result register is busy.
// The next item is taken back in IDLE; each item needs two dependent reads
// plus write-back. One item is in flight.
// The result register is separate: a new item is taken while the last result
// waits; a full result register with no taker holds off the next commit only.
// Reset: lists empty (valid bits over the 17 list heads), pool fills zero,
// one pool open, config at 65536 bytes and 8 pools. Block class/next stores
// are not cleared; the user ensures they are read only after writes by allocate.
module pow2_size_class_allocator (
    input  wire logic   clk,
    input  wire logic   rst_n,
    p2sca_req_if.sink   req,
    p2sca_rsp_if.source rsp,
    p2sca_cfg_if.sink   cfg
);
    import p2sca_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EXEC} state_t;

    state_t               state_reg, state_next;
    req_t                 item_reg;
    logic [FILL_W-1:0]    pool_size_reg;
    logic [POOL_CNT_W-1:0] pools_allowed_reg;
    logic [FILL_W-1:0]    fill_reg [NUM_POOLS];
    logic [POOL_CNT_W-1:0] open_reg;
    logic [LIST_DEPTH-1:0] head_vld_reg;
    logic                 rsp_vld_reg;
    rsp_t                 rsp_reg;
    logic [CLASS_W-1:0]   cls_reg;
    logic                 big_reg;      // rounded size beyond the limit
    logic [FILL_W:0]      size_reg;     // 2^cls up to 2^17, all ones beyond

    // limits
    logic [FILL_W-1:0] lim;
    logic [POOL_CNT_W-1:0] cap;
    assign lim = (pool_size_reg > FILL_W'(MAX_POOL_BYTES)) ? FILL_W'(MAX_POOL_BYTES)
                                                           : pool_size_reg;
    assign cap = (pools_allowed_reg > POOL_CNT_W'(NUM_POOLS)) ? POOL_CNT_W'(NUM_POOLS)
                                                               : pools_allowed_reg;

    // size class of the incoming request (ceil log2 of need)
    logic [32:0]        need;
    logic [32:0]        need_m1;
    logic [CLASS_W-1:0] cls_in;
    always_comb
    begin
        need    = {1'b0, req.payload.req_bytes} + 33'(HEADER_BYTES);
        need_m1 = need - 33'd1;
        cls_in  = '0;
        for (int i = 0; i < 32; i++)
        begin
            if (need_m1[i])
            begin
                cls_in = CLASS_W'(i + 1);
            end
        end
        if (need_m1[32])
        begin
            cls_in = CLASS_W'(31);
        end
    end

    // memories
    logic                 lh_we;
    logic [LIST_AW-1:0]   lh_waddr, lh_raddr;
    logic [ADDR_W-1:0]    lh_wdata, lh_rdata;
    logic                 bc_we;
    logic [CLASS_W-1:0]   bc_wdata, bc_rdata;
    logic                 bn_we;
    logic [ADDR_W-1:0]    bn_wdata, bn_rdata;
    logic [SLOT_W-1:0]    slot_w, slot_r;

    p2sca_ram #(.WIDTH(ADDR_W), .DEPTH(LIST_DEPTH)) u_head (
        .clk(clk), .we(lh_we), .waddr(lh_waddr), .wdata(lh_wdata),
        .raddr(lh_raddr), .rdata(lh_rdata));
    p2sca_ram #(.WIDTH(CLASS_W), .DEPTH(1 << SLOT_W)) u_class (
        .clk(clk), .we(bc_we), .waddr(slot_w), .wdata(bc_wdata),
        .raddr(slot_r), .rdata(bc_rdata));
    p2sca_ram #(.WIDTH(ADDR_W), .DEPTH(1 << SLOT_W)) u_next (
        .clk(clk), .we(bn_we), .waddr(slot_w), .wdata(bn_wdata),
        .raddr(slot_r), .rdata(bn_rdata));

    // Class index into a 17-entry head store; classes above 16 never reach it
    // (too large for any limit), so clamping them to entry 16 is safe.
    function automatic logic [LIST_AW-1:0] head_idx(input logic [CLASS_W-1:0] c);
        head_idx = (c > CLASS_W'(LIST_DEPTH - 1)) ? LIST_AW'(LIST_DEPTH - 1) : c;
    endfunction

    // First read cycle: head of the request class and the slot class.
    // Second read cycle: alloc reads the head's next link, free reads the head
    // of the stored class. Both addresses stay put through EXEC stalls.
    logic                 phase_reg;    // 0 first read, 1 second read
    logic [ADDR_W-1:0]    head_val_reg;
    logic [ADDR_W-1:0]    head_cur;
    logic [ADDR_W-1:0]    free_head;

    assign head_cur  = head_vld_reg[head_idx(cls_reg)] ? lh_rdata : '0;
    assign free_head = head_vld_reg[head_idx(bc_rdata)] ? lh_rdata : '0;

    assign lh_raddr = head_idx((item_reg.op == OP_FREE &&
                                ((state_reg == S_READ && phase_reg) || state_reg == S_EXEC))
                               ? bc_rdata : cls_reg);
    assign slot_r   = (item_reg.op == OP_ALLOC && state_reg == S_READ && phase_reg)
                      ? head_cur[SLOT_LSB +: SLOT_W]
                      : (item_reg.op == OP_ALLOC && state_reg == S_EXEC)
                        ? head_val_reg[SLOT_LSB +: SLOT_W]
                        : item_reg.block_addr[SLOT_LSB +: SLOT_W];

    // pool search
    logic                 found;
    logic [POOL_W-1:0]    pick;
    always_comb
    begin
        found = 1'b0;
        pick  = '0;
        for (int p = NUM_POOLS - 1; p >= 0; p--)
        begin
            if (POOL_CNT_W'(p) < open_reg && fill_reg[p] <= lim &&
                ({1'b0, lim} - {1'b0, fill_reg[p]}) >= size_reg)
            begin
                found = 1'b1;
                pick  = POOL_W'(p);
            end
        end
    end

    logic              rsp_free;
    logic              commit;
    assign rsp_free = !rsp_vld_reg || rsp.ready;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_vld_reg;
    assign rsp.payload = rsp_reg;

    // EXEC decisions
    logic [FILL_W-1:0] lim_cmp;
    logic              pop;
    logic [POOL_W-1:0] use_pool;
    logic              no_room;
    logic [ADDR_W-1:0] bump_addr;
    logic [CLASS_W-1:0] fcls;
    logic              free_keep;
    rsp_t              res;
    always_comb
    begin
        lim_cmp   = lim;
        pop       = (head_val_reg != '0);
        no_room   = !found && (open_reg >= cap);
        use_pool  = found ? pick : open_reg[POOL_W-1:0];
        bump_addr = ADDR_W'({use_pool, {POOL_SHIFT{1'b0}}})
                    + ADDR_W'(fill_reg[use_pool]) + ADDR_W'(HEADER_BYTES);
        fcls      = bc_rdata;
        free_keep = ({1'b0, lim_cmp} >= (18'd1 << fcls)) && (fcls <= CLASS_W'(17));
        res       = '0;
        lh_we = 1'b0; lh_waddr = head_idx(cls_reg); lh_wdata = '0;
        bc_we = 1'b0; bc_wdata = cls_reg;
        bn_we = 1'b0; bn_wdata = '0;
        slot_w = item_reg.block_addr[SLOT_LSB +: SLOT_W];
        commit = (state_reg == S_EXEC) && rsp_free;
        if (item_reg.op == OP_ALLOC)
        begin
            if (item_reg.req_bytes == '0)
            begin
                res.status = ST_IGNORED;
            end
            else if (big_reg)
            begin
                res.status = ST_TOO_LARGE;
            end
            else if (pop)
            begin
                res.addr_out = head_val_reg;
                res.reused   = 1'b1;
                lh_we    = commit;
                lh_wdata = bn_rdata;
                bn_we    = commit;
                slot_w   = head_val_reg[SLOT_LSB +: SLOT_W];
            end
            else if (no_room)
            begin
                res.status = ST_NO_POOLS;
            end
            else
            begin
                res.addr_out = bump_addr;
                bc_we  = commit;
                bn_we  = commit;
                slot_w = bump_addr[SLOT_LSB +: SLOT_W];
            end
        end
        else if (item_reg.block_addr == '0)
        begin
            res.status = ST_IGNORED;
        end
        else if (free_keep)
        begin
            lh_we    = commit;
            lh_waddr = head_idx(fcls);
            lh_wdata = item_reg.block_addr;
            bn_we    = commit;
            bn_wdata = free_head;
        end
    end

    logic [FILL_W-1:0] sz17;
    assign sz17 = size_reg[FILL_W-1:0];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (req.valid) state_next = S_READ;
            S_READ: if (phase_reg) state_next = S_EXEC;
            S_EXEC: if (rsp_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            pool_size_reg     <= FILL_W'(MAX_POOL_BYTES);
            pools_allowed_reg <= POOL_CNT_W'(NUM_POOLS);
            open_reg          <= POOL_CNT_W'(1);
            head_vld_reg      <= '0;
            rsp_vld_reg       <= 1'b0;
            phase_reg         <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                if (cfg.payload.index == CFG_POOL_SIZE)
                begin
                    pool_size_reg <= cfg.payload.data[FILL_W-1:0];
                end
                else
                begin
                    pools_allowed_reg <= cfg.payload.data[POOL_CNT_W-1:0];
                end
            end
            if (commit)
            begin
                rsp_vld_reg <= 1'b1;
            end
            else if (rsp_vld_reg && rsp.ready)
            begin
                rsp_vld_reg <= 1'b0;
            end
            if (state_reg == S_READ)
            begin
                phase_reg <= !phase_reg;
            end
            if (commit)
            begin
                if (lh_we)
                begin
                    head_vld_reg[lh_waddr] <= 1'b1;
                end
                if (item_reg.op == OP_ALLOC && item_reg.req_bytes != '0 && !big_reg
                    && !pop && !no_room)
                begin
                    fill_reg[use_pool] <= fill_reg[use_pool] + sz17;
                    if (!found)
                    begin
                        open_reg <= open_reg + POOL_CNT_W'(1);
                    end
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg <= req.payload;
            cls_reg  <= cls_in;
            size_reg <= (cls_in > CLASS_W'(FILL_W)) ? '1 : ((FILL_W+1)'(1) << cls_in);
            big_reg  <= (need > {16'd0, lim}) || (cls_in > CLASS_W'(FILL_W))
                        || (((FILL_W+1)'(1) << cls_in) > {1'b0, lim});
        end
        if (state_reg == S_READ && phase_reg && item_reg.op == OP_ALLOC)
        begin
            head_val_reg <= head_cur;
        end
        if (commit)
        begin
            rsp_reg <= res;
        end
    end

    // free-list head is always nonzero only once written
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EXEC && !head_vld_reg[head_idx(cls_reg)] && item_reg.op == OP_ALLOC)
        |-> (head_val_reg == '0))
        else $error("unwritten list head read as nonzero");
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg >= POOL_CNT_W'(1) && open_reg <= POOL_CNT_W'(NUM_POOLS))
        else $error("open pool count out of range");
    assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> rsp_vld_reg)
        else $error("committed item without result");
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == S_READ))
        else $error("accepted item not in flight");
endmodule
`default_nettype wire

### bench/p2sca_checker.sv
`timescale 1ns / 100ps
module p2sca_checker
    import p2sca_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    p2sca_req_if  req,
    p2sca_rsp_if  rsp,
    p2sca_cfg_if  cfg,
    output int    errors,
    output int    pending
);
    logic [FILL_W-1:0]     pool_size_q;
    logic [POOL_CNT_W-1:0] pools_allowed_q;
    logic [ADDR_W-1:0]     free_head [CLASS_COUNT];
    longint                pool_used [NUM_POOLS];
    int                    open_pools;
    logic [CLASS_W-1:0]    slot_class [1 << SLOT_W];
    logic [ADDR_W-1:0]     slot_link [1 << SLOT_W];
    rsp_t                  expected_q [$];

    // Applies one request to the shadow allocator and returns its result.
    function automatic rsp_t serve_request(req_t it);
        rsp_t   r;
        longint lim;
        longint need;
        longint size;
        longint room;
        int     cls;
        int     p;
        int     cap;
        int     s;
        bit     found;
        logic [ADDR_W-1:0] a;
        r = '0;
        lim = (pool_size_q > MAX_POOL_BYTES) ? MAX_POOL_BYTES : pool_size_q;
        if (it.op == OP_FREE)
        begin
            if (it.block_addr == '0)
            begin
                r.status = ST_IGNORED;
                return r;
            end
            s = it.block_addr[ADDR_W-1:SLOT_LSB];
            cls = slot_class[s];
            if ((longint'(1) << cls) <= lim)
            begin
                slot_link[s] = free_head[cls];
                free_head[cls] = it.block_addr;
            end
            r.status = ST_OK;
            return r;
        end
        need = longint'(it.req_bytes) + HEADER_BYTES;
        if (it.req_bytes == '0)
        begin
            r.status = ST_IGNORED;
            return r;
        end
        if (need > lim)
        begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        size = 1;
        cls = 0;
        while (size < need && cls < CLASS_COUNT - 1)
        begin
            size = size << 1;
            cls++;
        end
        if (size > lim)
        begin
            r.status = ST_TOO_LARGE;
            return r;
        end
        if (free_head[cls] != '0)
        begin
            a = free_head[cls];
            s = a[ADDR_W-1:SLOT_LSB];
            free_head[cls] = slot_link[s];
            slot_link[s] = '0;
            r.addr_out = a;
            r.reused = 1'b1;
            r.status = ST_OK;
            return r;
        end
        cap = (pools_allowed_q > NUM_POOLS) ? NUM_POOLS : pools_allowed_q;
        found = 0;
        p = 0;
        while (p < open_pools && !found)
        begin
            room = (pool_used[p] > lim) ? 0 : lim - pool_used[p];
            if (room >= size)
                found = 1;
            else
                p++;
        end
        if (!found)
        begin
            if (open_pools >= cap)
            begin
                r.status = ST_NO_POOLS;
                return r;
            end
            p = open_pools;
            open_pools++;
        end
        a = ADDR_W'(longint'(p) * MAX_POOL_BYTES + pool_used[p] + HEADER_BYTES);
        pool_used[p] += size;
        s = a[ADDR_W-1:SLOT_LSB];
        slot_class[s] = CLASS_W'(cls);
        slot_link[s] = '0;
        r.addr_out = a;
        r.status = ST_OK;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            pool_size_q = FILL_W'(65536);
            pools_allowed_q = POOL_CNT_W'(8);
            for (int i = 0; i < CLASS_COUNT; i++)
                free_head[i] = '0;
            for (int i = 0; i < NUM_POOLS; i++)
                pool_used[i] = 0;
            open_pools = 1;
            expected_q.delete();
            errors = 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.payload.index == CFG_POOL_SIZE)
                    pool_size_q = cfg.payload.data[FILL_W-1:0];
                else
                    pools_allowed_q = cfg.payload.data[POOL_CNT_W-1:0];
            end
            if (rsp.valid && rsp.ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result item: addr_out %0h status %0d reused %0d",
                           rsp.payload.addr_out, rsp.payload.status, rsp.payload.reused);
                    errors++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (rsp.payload.addr_out !== want.addr_out)
                    begin
                        $error("addr_out: expected %0h actual %0h",
                               want.addr_out, rsp.payload.addr_out);
                        errors++;
                    end
                    if (rsp.payload.status !== want.status)
                    begin
                        $error("status: expected %0d actual %0d",
                               want.status, rsp.payload.status);
                        errors++;
                    end
                    if (rsp.payload.reused !== want.reused)
                    begin
                        $error("reused: expected %0d actual %0d",
                               want.reused, rsp.payload.reused);
                        errors++;
                    end
                end
            end
            if (req.valid && req.ready)
                expected_q.push_back(serve_request(req.payload));
        end
        pending = expected_q.size();
    end
endmodule

### bench/pow2_size_class_allocator_tb.sv
`timescale 1ns / 100ps
module pow2_size_class_allocator_tb;
    import p2sca_pkg::*;

    localparam int  CYCLE_LIMIT  = 2000000;
    localparam int  RANDOM_ITEMS = 125;   // per config phase, six phases
    localparam int  LONG_HOLD    = 300;   // cycles of rsp backpressure

    logic clk;
    logic rst_n;
    int   errors;
    int   pending;
    int   cycles;
    bit   no_gaps;          // burst stretches: neither side idles
    bit   long_hold_req;    // one-shot request for a long rsp stall
    int   cur_pool_size;

    // Addresses handed out by the block: still live, and the last 256
    // seen (double and aliased frees; their slots are known written).
    logic [ADDR_W-1:0] live_addrs [$];
    logic [ADDR_W-1:0] seen_addrs [$];

    p2sca_req_if req_ch ();
    p2sca_rsp_if rsp_ch ();
    p2sca_cfg_if cfg_ch ();

    pow2_size_class_allocator DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    p2sca_checker u_checker (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #4 clk = ~clk;

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Harvest addresses that the block returned, so frees only ever name
    // slots that an allocate has written.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready
            && rsp_ch.payload.status == ST_OK && rsp_ch.payload.addr_out != '0)
        begin
            live_addrs.push_back(rsp_ch.payload.addr_out);
            seen_addrs.push_back(rsp_ch.payload.addr_out);
            if (seen_addrs.size() > 256)
                void'(seen_addrs.pop_front());
        end
    end

    // Mostly no gap, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Result side: random stalls plus the one long hold.
    initial
    begin
        int n;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold_req)
            begin
                long_hold_req = 0;
                n = LONG_HOLD;
            end
            else
                n = pick_gap();
            if (n == 0)
            begin
                rsp_ch.ready <= 1'b1;
                @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    end

    // Offer one request item; valid stays up between back-to-back items.
    task automatic send_item(logic op, logic [31:0] bytes, logic [ADDR_W-1:0] addr);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.payload <= '{op: op, req_bytes: bytes, block_addr: addr};
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
    endtask

    // Valid stays up between back-to-back writes; the caller drops it.
    task automatic write_reg(logic idx, logic [31:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.payload <= '{index: idx, data: value};
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
    endtask

    // Drain every result, let the block settle, then reprogram it.
    task automatic set_config(int psize, int pools);
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
        write_reg(CFG_POOL_SIZE, 32'(psize));
        write_reg(CFG_POOLS_ALLOWED, 32'(pools));
        cfg_ch.valid <= 1'b0;
        cur_pool_size = psize & 32'h1FFFF;
    endtask

    // Payload sizes: mostly within the current pool limit across all
    // classes, with zero, huge and near-limit values mixed in.
    function automatic logic [31:0] pick_bytes();
        int lim;
        int r;
        int k;
        lim = (cur_pool_size > MAX_POOL_BYTES) ? MAX_POOL_BYTES : cur_pool_size;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 9)
            return $urandom();
        if (r < 16)
            return $urandom_range(lim + 8, (lim > 24) ? lim - 24 : 1);
        k = $urandom_range(0, 16);
        while (k > 0 && (1 << k) > lim)
            k--;
        return $urandom_range(1, 1 << k);
    endfunction

    task automatic free_something();
        int r;
        int idx;
        logic [ADDR_W-1:0] a;
        r = $urandom_range(0, 99);
        if (r < 8 || seen_addrs.size() == 0)
            send_item(OP_FREE, $urandom(), '0);
        else if (r < 78 && live_addrs.size() > 0)
        begin
            idx = $urandom_range(0, live_addrs.size() - 1);
            a = live_addrs[idx];
            live_addrs.delete(idx);
            send_item(OP_FREE, $urandom(), a);
        end
        else
        begin
            // double free, or the same slot with other low address bits
            a = seen_addrs[$urandom_range(0, seen_addrs.size() - 1)];
            if (r >= 90)
                a[SLOT_LSB-1:0] = $urandom();
            send_item(OP_FREE, $urandom(), a);
        end
    endtask

    task automatic random_phase(int items, int alloc_pct);
        repeat (items)
        begin
            if ($urandom_range(0, 19) == 0)
                no_gaps = ~no_gaps;
            if ($urandom_range(0, 99) < alloc_pct)
                send_item(OP_ALLOC, pick_bytes(), $urandom());
            else
                free_something();
        end
        no_gaps = 0;
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        cycles = 0;
        no_gaps = 0;
        long_hold_req = 0;
        cur_pool_size = 65536;
        req_ch.valid = 1'b0;
        req_ch.payload = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.payload = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: field extremes and each special case.
        send_item(OP_ALLOC, 32'd0, '0);              // zero size ignored
        send_item(OP_FREE, 32'hFFFF_FFFF, '0);       // null free ignored
        send_item(OP_ALLOC, 32'd1, '1);              // smallest class
        send_item(OP_ALLOC, 32'd65520, '0);          // exactly one pool
        send_item(OP_ALLOC, 32'd65521, '0);          // too large
        send_item(OP_ALLOC, 32'hFFFF_FFFF, '0);      // far too large
        send_item(OP_ALLOC, 32'd48, '0);
        send_item(OP_ALLOC, 32'd1000, '0);
        set_config(65536, 8);                        // sender waits for all
        send_item(OP_FREE, '0, 19'd16);              // first block back
        send_item(OP_ALLOC, 32'd7, '0);              // served from list
        send_item(OP_ALLOC, 32'd7, '0);              // list empty again
        send_item(OP_ALLOC, 32'd40000, '0);          // opens more pools
        send_item(OP_ALLOC, 32'd40000, '0);

        // Long result stall while requests keep coming: block backs up.
        long_hold_req = 1;
        repeat (12)
            send_item(OP_ALLOC, 32'd20, '0);

        // Random phases over several settings, extremes among them.
        random_phase(RANDOM_ITEMS, 65);
        set_config(32, 8);              // one block per pool, overfull pools
        random_phase(RANDOM_ITEMS, 60);
        set_config(1000, 3);
        random_phase(RANDOM_ITEMS, 55);
        set_config(65536, 1);           // one pool allowed, out of pools soon
        random_phase(RANDOM_ITEMS, 55);
        set_config(4096, 15);           // pool count above the cap
        random_phase(RANDOM_ITEMS, 55);
        set_config(131071, 8);          // size above the pool maximum
        random_phase(RANDOM_ITEMS, 55);

        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
